[rtl/sdt_pkg.sv]
// Package for the sky dome texcoord fan block: codes, constants and the
// command/status structs between controller and datapath. No dependencies.
package sdt_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EYE_X  = 3'd0;
    localparam logic [2:0] CFG_EYE_Y  = 3'd1;
    localparam logic [2:0] CFG_EYE_Z  = 3'd2;
    localparam logic [2:0] CFG_SCROLL = 3'd3;

    // Squared component selects.
    localparam logic [1:0] SQ_X = 2'd0;
    localparam logic [1:0] SQ_Y = 2'd1;
    localparam logic [1:0] SQ_Z = 2'd2;

    // Emitted vertex selects.
    localparam logic [1:0] SEL_ANCHOR = 2'd0;
    localparam logic [1:0] SEL_PREV   = 2'd1;
    localparam logic [1:0] SEL_CUR    = 2'd2;

    // Sky scale 378 in the signed Q11.9 output grid (378 * 512).
    localparam int SKY_SCALE_Q = 193536;

    // Iteration counts of the square root and the divider.
    localparam int RT_STEPS = 26;
    localparam int DV_STEPS = 18;

    typedef struct packed {
        logic       cap;
        logic       acc;
        logic [1:0] acc_sel;
        logic       rt_init;
        logic       rt_step;
        logic       dv_init;
        logic       dv_step;
        logic       commit;
        logic [1:0] out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic fan_full;
    } t_dp_sts;

endpackage

[rtl/sdt_vtx_if.sv]
// Input channel of the sky dome texcoord fan block: one polygon vertex.
// Depends on nothing.
interface sdt_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               polygon_start;

    modport source (output valid, pos_x, pos_y, pos_z, polygon_start, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, polygon_start, output ready);
endinterface

[rtl/sdt_tex_if.sv]
// Output channel of the sky dome texcoord fan block: one triangle-list vertex.
// Depends on nothing.
interface sdt_tex_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic signed [20:0] tex_s;
    logic signed [20:0] tex_t;
    logic               end_of_triangle;

    modport source (output valid, out_x, out_y, out_z, tex_s, tex_t, end_of_triangle,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, tex_s, tex_t, end_of_triangle,
                    output ready);
endinterface

[rtl/sdt_ctrl.sv]
// Controller of the sky dome texcoord fan block: sequences capture, squares,
// square root, division and emission. Depends on sdt_pkg.
module sdt_ctrl
    import sdt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_RTI    = 4'd2;
    localparam logic [3:0] ST_RT     = 4'd3;
    localparam logic [3:0] ST_DVI    = 4'd4;
    localparam logic [3:0] ST_DV     = 4'd5;
    localparam logic [3:0] ST_EMIT0  = 4'd6;
    localparam logic [3:0] ST_EMIT1  = 4'd7;
    localparam logic [3:0] ST_EMIT2  = 4'd8;
    localparam logic [3:0] ST_COMMIT = 4'd9;

    localparam logic [4:0] RT_LAST = 5'(RT_STEPS - 1);
    localparam logic [4:0] DV_LAST = 5'(DV_STEPS - 1);

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_SQ;
                    n_cnt     = '0;
                end
            end
            ST_SQ: begin
                o_cmd.acc     = 1'b1;
                o_cmd.acc_sel = r_cnt[1:0];
                if (r_cnt[1:0] == SQ_Z) begin
                    n_state = ST_RTI;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_RTI: begin
                o_cmd.rt_init = 1'b1;
                n_state       = ST_RT;
                n_cnt         = '0;
            end
            ST_RT: begin
                o_cmd.rt_step = 1'b1;
                if (r_cnt == RT_LAST) begin
                    n_state = ST_DVI;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_DVI: begin
                o_cmd.dv_init = 1'b1;
                n_state       = ST_DV;
                n_cnt         = '0;
            end
            ST_DV: begin
                o_cmd.dv_step = 1'b1;
                if (r_cnt == DV_LAST) begin
                    n_state = i_sts.fan_full ? ST_EMIT0 : ST_COMMIT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_EMIT0: begin
                o_out_valid   = 1'b1;
                o_cmd.out_sel = SEL_ANCHOR;
                if (i_out_ready) begin
                    n_state = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                o_out_valid   = 1'b1;
                o_cmd.out_sel = SEL_PREV;
                if (i_out_ready) begin
                    n_state = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                o_out_valid   = 1'b1;
                o_cmd.out_sel = SEL_CUR;
                if (i_out_ready) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sdt_dp.sv]
// Datapath of the sky dome texcoord fan block: configuration registers,
// squares, bitwise square root, restoring divider and fan storage. Depends on sdt_pkg.
module sdt_dp
    import sdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic               i_polygon_start,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y,
    output logic signed [23:0] o_out_z,
    output logic signed [20:0] o_tex_s,
    output logic signed [20:0] o_tex_t,
    output logic               o_end_of_triangle
);

    function automatic logic [25:0] mag27(input logic signed [26:0] v);
        logic [26:0] a;
        a = v[26] ? 27'(-v) : 27'(v);
        return a[25:0];
    endfunction

    // Configuration.
    logic signed [23:0] r_eye_x, r_eye_y, r_eye_z;
    logic [14:0]        r_scroll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x  <= '0;
            r_eye_y  <= '0;
            r_eye_z  <= '0;
            r_scroll <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EYE_X:  r_eye_x  <= i_cfg_data;
                CFG_EYE_Y:  r_eye_y  <= i_cfg_data;
                CFG_EYE_Z:  r_eye_z  <= i_cfg_data;
                CFG_SCROLL: r_scroll <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Current vertex and its direction from the eye.
    logic signed [23:0] r_px, r_py, r_pz;
    logic               r_start;
    logic signed [26:0] r_dx, r_dy, r_dz3;
    logic signed [26:0] dz;

    assign dz = 27'(i_pos_z) - 27'(r_eye_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_pz    <= i_pos_z;
            r_start <= i_polygon_start;
            r_dx    <= 27'(i_pos_x) - 27'(r_eye_x);
            r_dy    <= 27'(i_pos_y) - 27'(r_eye_y);
            r_dz3   <= dz + (dz <<< 1);
        end
    end

    // Sum of squares, one component per cycle.
    logic [52:0] r_acc;
    logic [25:0] sq_in;
    logic [51:0] sq;

    always_comb begin
        case (i_cmd.acc_sel)
            SQ_X:    sq_in = mag27(r_dx);
            SQ_Y:    sq_in = mag27(r_dy);
            default: sq_in = mag27(r_dz3);
        endcase
    end

    assign sq = 52'(sq_in) * 52'(sq_in);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + 53'(sq);
        end
    end

    // Square root, one result bit per cycle.
    logic [52:0] r_rn, r_res, r_bit;
    logic [52:0] rt_trial;
    logic [25:0] len;

    assign rt_trial = r_res + r_bit;
    assign len      = r_res[25:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_init) begin
            r_rn  <= r_acc;
            r_res <= '0;
            r_bit <= 53'd1 << (2 * (RT_STEPS - 1));
        end else if (i_cmd.rt_step) begin
            if (r_rn >= rt_trial) begin
                r_rn  <= r_rn - rt_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Two restoring dividers, s and t side by side, one quotient bit per cycle.
    logic [41:0] num_s, num_t;
    logic [25:0] r_rs, r_rt;
    logic [17:0] r_qs, r_qt;
    logic [26:0] rem2_s, rem2_t;
    logic        ge_s, ge_t;

    assign num_s  = 42'(mag27(r_dx)) * 42'(SKY_SCALE_Q);
    assign num_t  = 42'(mag27(r_dy)) * 42'(SKY_SCALE_Q);
    assign rem2_s = {r_rs, r_qs[17]};
    assign rem2_t = {r_rt, r_qt[17]};
    assign ge_s   = rem2_s >= {1'b0, len};
    assign ge_t   = rem2_t >= {1'b0, len};

    always_ff @(posedge i_clk) begin
        if (i_cmd.dv_init) begin
            r_rs <= {2'b0, num_s[41:18]};
            r_qs <= num_s[17:0];
            r_rt <= {2'b0, num_t[41:18]};
            r_qt <= num_t[17:0];
        end else if (i_cmd.dv_step) begin
            r_rs <= ge_s ? 26'(rem2_s - {1'b0, len}) : rem2_s[25:0];
            r_qs <= {r_qs[16:0], ge_s};
            r_rt <= ge_t ? 26'(rem2_t - {1'b0, len}) : rem2_t[25:0];
            r_qt <= {r_qt[16:0], ge_t};
        end
    end

    // Texture coordinates of the current vertex.
    logic signed [20:0] base, q_s, q_t, cur_s, cur_t;

    assign base  = {5'b0, r_scroll, 1'b0};
    assign q_s   = (len == '0) ? '0 : {3'b0, r_qs};
    assign q_t   = (len == '0) ? '0 : {3'b0, r_qt};
    assign cur_s = base + (r_dx[26] ? -q_s : q_s);
    assign cur_t = base + (r_dy[26] ? -q_t : q_t);

    // Fan storage: anchor and previous vertex.
    logic signed [23:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [20:0] r_as, r_at, r_bs, r_bt;
    logic [1:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_start || r_count == 2'd0) begin
                r_count <= 2'd1;
            end else begin
                r_count <= 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_start || r_count == 2'd0) begin
                r_ax <= r_px;
                r_ay <= r_py;
                r_az <= r_pz;
                r_as <= cur_s;
                r_at <= cur_t;
            end else begin
                r_bx <= r_px;
                r_by <= r_py;
                r_bz <= r_pz;
                r_bs <= cur_s;
                r_bt <= cur_t;
            end
        end
    end

    assign o_sts.fan_full = !r_start && r_count == 2'd2;

    // Emitted vertex select.
    always_comb begin
        o_end_of_triangle = 1'b0;
        case (i_cmd.out_sel)
            SEL_ANCHOR: begin
                o_out_x = r_ax; o_out_y = r_ay; o_out_z = r_az;
                o_tex_s = r_as; o_tex_t = r_at;
            end
            SEL_PREV: begin
                o_out_x = r_bx; o_out_y = r_by; o_out_z = r_bz;
                o_tex_s = r_bs; o_tex_t = r_bt;
            end
            default: begin
                o_out_x = r_px; o_out_y = r_py; o_out_z = r_pz;
                o_tex_s = cur_s; o_tex_t = cur_t;
                o_end_of_triangle = 1'b1;
            end
        endcase
    end

endmodule

[rtl/sky_dome_texcoord_fan_top.sv]
// Top level of the sky dome texcoord fan block: joins controller and datapath.
// Depends on sdt_pkg, sdt_vtx_if, sdt_tex_if, sdt_ctrl and sdt_dp.
//
//   channel  | direction | request
//   i_vtx    | in        | one polygon vertex with its polygon start flag
//   o_tex    | out       | one triangle-list vertex with sky texcoords
//   i_cfg_*  | in        | register write, no handshake
//
// After capture a vertex passes through the squares, the bitwise square root
// and the shared-step divider, then commit.
// A vertex that closes a triangle adds three output vertices, each held until taken.
// One vertex is in work at a time; i_vtx.ready is high only when idle.
// Reset is synchronous and clears the eye, the scroll and the fan count.
module sky_dome_texcoord_fan_top
    import sdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdt_vtx_if.sink     i_vtx,
    sdt_tex_if.source   o_tex,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    sdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .o_in_ready  (i_vtx.ready),
        .o_out_valid (o_tex.valid),
        .i_out_ready (o_tex.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and storage.
    sdt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_pos_x           (i_vtx.pos_x),
        .i_pos_y           (i_vtx.pos_y),
        .i_pos_z           (i_vtx.pos_z),
        .i_polygon_start   (i_vtx.polygon_start),
        .o_out_x           (o_tex.out_x),
        .o_out_y           (o_tex.out_y),
        .o_out_z           (o_tex.out_z),
        .o_tex_s           (o_tex.tex_s),
        .o_tex_t           (o_tex.tex_t),
        .o_end_of_triangle (o_tex.end_of_triangle)
    );

endmodule

[rtl/sdt_chk.sv]
// Port checker of the sky dome texcoord fan block, bound to the top level.
// Depends on sky_dome_texcoord_fan_top.
module sdt_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_eot
);

    // A waiting output stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    // No vertex is taken while a result is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken during emission");

    // After an accepted vertex the block is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an accepted request");

    // Triangle vertices come as one group of three.
    a_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_eot |=> i_out_valid)
        else $error("triangle cut short");

    // The last vertex of a triangle is followed by a gap.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_eot |=> !i_out_valid)
        else $error("output right after end of triangle");

endmodule

bind sky_dome_texcoord_fan_top sdt_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_tex.valid),
    .i_out_ready (o_tex.ready),
    .i_eot       (o_tex.end_of_triangle)
);
